[design/iir_bandpass_biquad_cascade_macros.svh]
// assertion macros used by the checker
`ifndef IIR_BANDPASS_BIQUAD_CASCADE_MACROS_SVH
`define IIR_BANDPASS_BIQUAD_CASCADE_MACROS_SVH

// same-cycle implication
`define IIRBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/iirbp_pkg.sv]
package iirbp_pkg;

    localparam int STATE_WIDTH_DEF   = 48;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SAMPLE_WIDTH      = 10;
    localparam int OUT_WIDTH         = 24;
    localparam int OUT_FRAC          = 8;
    localparam int SECTIONS          = 4;
    localparam int SEC_WIDTH         = $clog2(SECTIONS);
    localparam int COEF_WIDTH        = 32;
    localparam int COEF_SHIFT        = 30;
    localparam int MUL_SPLIT         = 32;

    typedef logic [SEC_WIDTH-1:0]         sec_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // section with a fully multiplied numerator, and the one with a plus sign on 2*z1
    localparam sec_t SEC_LP_MUL = sec_t'(0);
    localparam sec_t SEC_LP_ADD = sec_t'(1);
    localparam sec_t SEC_LAST   = sec_t'(SECTIONS - 1);

    localparam coef_t COEF_A1 [SECTIONS] = '{
        -32'sd1024256821, -32'sd1294896455, -32'sd2122687138, -32'sd2137515963
    };
    localparam coef_t COEF_A2 [SECTIONS] = '{
        32'sd271778616, 32'sd650240139, 32'sd1049114428, 32'sd1063936553
    };
    localparam coef_t LP_B0 = 32'sd7895030;
    localparam coef_t LP_B1 = 32'sd15790061;
    localparam coef_t LP_B2 = 32'sd7895030;

    typedef enum logic [2:0] {TAP_A1, TAP_A2, TAP_B0, TAP_B1, TAP_B2} tap_t;
    typedef enum logic [1:0] {MUL_Z1, MUL_Z2, MUL_W} mul_src_t;
    typedef enum logic [1:0] {A_X, A_ACC, A_W} acc_a_t;
    typedef enum logic [1:0] {B_PROD, B_TWICE, B_Z2} acc_b_t;
    typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} acc_op_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_issue;
        mul_src_t mul_src;
        tap_t     tap;
        logic     prod_load;
        logic     acc_en;
        acc_a_t   a_sel;
        acc_b_t   b_sel;
        acc_op_t  op;
        logic     w_load;
        logic     commit;
        logic     out_load;
        sec_t     sec;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic coef_t coef_lookup(input sec_t sec, input tap_t tap);
        coef_t c;
        c = '0;
        unique case (tap)
            TAP_A1:  c = COEF_A1[sec];
            TAP_A2:  c = COEF_A2[sec];
            TAP_B0:  c = LP_B0;
            TAP_B1:  c = LP_B1;
            TAP_B2:  c = LP_B2;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[design/iir_bandpass_biquad_cascade.sv]
// four-section biquad band-pass, 0.5 to 29.5 Hz at a 256 Hz sample rate
// input channel: in_valid / in_stall carry one 10-bit unsigned sample per request;
//   a request is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carry one 24-bit signed filtered value
//   (8 fraction bits, saturated) per input request
// one shared multiply stage forms every coefficient product from two partial
//   products of the operand split at bit 32 (issue, recombine, accumulate)
// after the input request is taken, the first section needs 5 products, each of
//   the other three needs 2 products and 2 add steps, and the result is then
//   loaded into the output register once that register is free
// in_stall is high while a sample is being filtered and until its result is
//   loaded into the output register; no new request is taken meanwhile
// stall: the output register holds its value while out_stall is high; a new
//   input is still taken meanwhile, and a finished result waits inside until
//   the output register is free
// reset: rst_n clears all section delay words to zero and empties the output
module iir_bandpass_biquad_cascade #(
    parameter int STATE_WIDTH   = iirbp_pkg::STATE_WIDTH_DEF,
    parameter int FRACTION_BITS = iirbp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [iirbp_pkg::SAMPLE_WIDTH-1:0]      sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [iirbp_pkg::OUT_WIDTH-1:0]  filtered
);

    iirbp_pkg::cmd_t    cmd;
    iirbp_pkg::status_t status;

    iirbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    iirbp_dp #(
        .STATE_WIDTH   (STATE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered)
    );

endmodule

[design/iirbp_ctrl.sv]
module iirbp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  iirbp_pkg::status_t status,
    output iirbp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_PROD, ST_ACC, ST_OUT} state_t;
    typedef enum logic [2:0] {STEP_FB1, STEP_FB2, STEP_NUM0, STEP_NUM1, STEP_NUM2} step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    iirbp_pkg::sec_t   sec_reg, sec_next;

    iirbp_pkg::mul_src_t mul_src;
    iirbp_pkg::tap_t     tap;
    iirbp_pkg::acc_a_t   a_sel;
    iirbp_pkg::acc_b_t   b_sel;
    iirbp_pkg::acc_op_t  op;
    logic                w_flag;
    logic                last_step;
    logic                full_mul;

    assign full_mul = (sec_reg == iirbp_pkg::SEC_LP_MUL);

    // per-step decode
    always_comb
    begin
        mul_src   = iirbp_pkg::MUL_Z1;
        tap       = iirbp_pkg::TAP_A1;
        a_sel     = iirbp_pkg::A_ACC;
        b_sel     = iirbp_pkg::B_PROD;
        op        = iirbp_pkg::OP_ADD;
        w_flag    = 1'b0;
        last_step = 1'b0;
        unique case (step_reg)
            STEP_FB1:
            begin
                mul_src = iirbp_pkg::MUL_Z1;
                tap     = iirbp_pkg::TAP_A1;
                a_sel   = iirbp_pkg::A_X;
                op      = iirbp_pkg::OP_SUB;
            end
            STEP_FB2:
            begin
                mul_src = iirbp_pkg::MUL_Z2;
                tap     = iirbp_pkg::TAP_A2;
                op      = iirbp_pkg::OP_SUB;
                w_flag  = 1'b1;
            end
            STEP_NUM0:
            begin
                mul_src = iirbp_pkg::MUL_W;
                tap     = iirbp_pkg::TAP_B0;
                if (full_mul)
                begin
                    op = iirbp_pkg::OP_LOAD;
                end
                else
                begin
                    a_sel = iirbp_pkg::A_W;
                    b_sel = iirbp_pkg::B_TWICE;
                    op    = (sec_reg == iirbp_pkg::SEC_LP_ADD) ?
                            iirbp_pkg::OP_ADD : iirbp_pkg::OP_SUB;
                end
            end
            STEP_NUM1:
            begin
                mul_src = iirbp_pkg::MUL_Z1;
                tap     = iirbp_pkg::TAP_B1;
                if (!full_mul)
                begin
                    b_sel     = iirbp_pkg::B_Z2;
                    last_step = 1'b1;
                end
            end
            STEP_NUM2:
            begin
                mul_src   = iirbp_pkg::MUL_Z2;
                tap       = iirbp_pkg::TAP_B2;
                last_step = 1'b1;
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.sec     = sec_reg;
        cmd.mul_src = mul_src;
        cmd.tap     = tap;
        cmd.a_sel   = a_sel;
        cmd.b_sel   = b_sel;
        cmd.op      = op;
        state_next  = state_reg;
        step_next   = step_reg;
        sec_next    = sec_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    sec_next   = '0;
                    step_next  = STEP_FB1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_issue = 1'b1;
                state_next    = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod_load = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.w_load = w_flag;
                cmd.commit = last_step;
                if (last_step)
                begin
                    step_next = STEP_FB1;
                    if (sec_reg == iirbp_pkg::SEC_LAST)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sec_next   = sec_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    step_next  = step_t'(step_reg + 3'd1);
                    state_next = full_mul ? ST_MUL :
                                 ((step_reg == STEP_FB1) ? ST_MUL : ST_ACC);
                end
            end
            ST_OUT:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_FB1;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sec_reg   <= sec_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[design/iirbp_dp.sv]
module iirbp_dp #(
    parameter int STATE_WIDTH   = iirbp_pkg::STATE_WIDTH_DEF,
    parameter int FRACTION_BITS = iirbp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  iirbp_pkg::cmd_t                         cmd,
    output iirbp_pkg::status_t                      status,
    input  logic [iirbp_pkg::SAMPLE_WIDTH-1:0]      sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [iirbp_pkg::OUT_WIDTH-1:0]  filtered
);

    localparam int SW       = STATE_WIDTH;
    localparam int LO_WIDTH = iirbp_pkg::MUL_SPLIT;
    localparam int HI_WIDTH = SW - LO_WIDTH;
    localparam int CW       = iirbp_pkg::COEF_WIDTH;
    localparam int PW       = SW + CW;
    localparam int QW       = PW - iirbp_pkg::COEF_SHIFT;
    localparam int OSHIFT   = FRACTION_BITS - iirbp_pkg::OUT_FRAC;
    localparam int OW       = iirbp_pkg::OUT_WIDTH;

    typedef logic signed [SW-1:0] st_t;

    localparam st_t ST_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam st_t ST_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    st_t z1_reg [iirbp_pkg::SECTIONS];
    st_t z2_reg [iirbp_pkg::SECTIONS];
    st_t x_reg, acc_reg, w_reg, prod_reg;
    logic signed [LO_WIDTH+CW:0]   plo_reg;
    logic signed [HI_WIDTH+CW-1:0] phi_reg;
    logic signed [OW-1:0]          filtered_reg;
    logic                          out_valid_reg;

    st_t                   mul_a, a_val, b_val, twice, acc_next, prod_next, shifted;
    iirbp_pkg::coef_t      mul_c;
    logic signed [PW-1:0]  full;
    logic signed [QW-1:0]  q;
    logic signed [SW:0]    sum;
    logic [QW-SW:0]        q_top;
    logic [SW-OW:0]        o_top;
    logic signed [OW-1:0]  out_next;

    function automatic st_t sat1(input logic signed [SW:0] v);
        st_t r;
        if (v[SW] != v[SW-1])
        begin
            r = v[SW] ? ST_MIN : ST_MAX;
        end
        else
        begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // multiplier operand
    always_comb
    begin
        case (cmd.mul_src)
            iirbp_pkg::MUL_Z1: mul_a = z1_reg[cmd.sec];
            iirbp_pkg::MUL_Z2: mul_a = z2_reg[cmd.sec];
            default:           mul_a = w_reg;
        endcase
    end

    assign mul_c = iirbp_pkg::coef_lookup(cmd.sec, cmd.tap);

    // partial products recombined, floored and clamped
    assign full  = $signed({phi_reg, {LO_WIDTH{1'b0}}}) + PW'(plo_reg);
    assign q     = full[PW-1:iirbp_pkg::COEF_SHIFT];
    assign q_top = q[QW-1:SW-1];

    always_comb
    begin
        if ((&q_top) || !(|q_top))
        begin
            prod_next = q[SW-1:0];
        end
        else
        begin
            prod_next = q[QW-1] ? ST_MIN : ST_MAX;
        end
    end

    assign twice = sat1({z1_reg[cmd.sec][SW-1], z1_reg[cmd.sec]} +
                        {z1_reg[cmd.sec][SW-1], z1_reg[cmd.sec]});

    always_comb
    begin
        case (cmd.a_sel)
            iirbp_pkg::A_X:   a_val = x_reg;
            iirbp_pkg::A_ACC: a_val = acc_reg;
            default:          a_val = w_reg;
        endcase
        case (cmd.b_sel)
            iirbp_pkg::B_PROD:  b_val = prod_reg;
            iirbp_pkg::B_TWICE: b_val = twice;
            default:            b_val = z2_reg[cmd.sec];
        endcase
    end

    always_comb
    begin
        if (cmd.op == iirbp_pkg::OP_SUB)
        begin
            sum = {a_val[SW-1], a_val} - {b_val[SW-1], b_val};
        end
        else
        begin
            sum = {a_val[SW-1], a_val} + {b_val[SW-1], b_val};
        end
        acc_next = (cmd.op == iirbp_pkg::OP_LOAD) ? b_val : sat1(sum);
    end

    // output scaling and saturation
    assign shifted = x_reg >>> OSHIFT;
    assign o_top   = shifted[SW-1:OW-1];

    always_comb
    begin
        if ((&o_top) || !(|o_top))
        begin
            out_next = shifted[OW-1:0];
        end
        else
        begin
            out_next = shifted[SW-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= st_t'({sample, {FRACTION_BITS{1'b0}}});
        end
        if (cmd.mul_issue)
        begin
            plo_reg <= $signed({1'b0, mul_a[LO_WIDTH-1:0]}) * mul_c;
            phi_reg <= $signed(mul_a[SW-1:LO_WIDTH]) * mul_c;
        end
        if (cmd.prod_load)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.w_load)
        begin
            w_reg <= acc_next;
        end
        if (cmd.commit)
        begin
            x_reg <= acc_next;
        end
        if (cmd.out_load)
        begin
            filtered_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iirbp_pkg::SECTIONS; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                z2_reg[cmd.sec] <= z1_reg[cmd.sec];
                z1_reg[cmd.sec] <= w_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign filtered        = filtered_reg;

endmodule

[design/iirbp_chk.sv]
`include "iir_bandpass_biquad_cascade_macros.svh"

module iirbp_chk (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [iirbp_pkg::OUT_WIDTH-1:0]  filtered
);

    `IIRBP_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall, "not busy after request")
    `IIRBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filtered), "stalled output changed")
    `IIRBP_ASSERT_NOW(a_out_rise_idle, $rose(out_valid), !in_stall, "result shown while still busy")
    `IIRBP_ASSERT_NOW(a_idle_has_result, $fell(in_stall), out_valid, "went idle without a result")

endmodule

bind iir_bandpass_biquad_cascade iirbp_chk u_chk (.*);
